// ===== design/mfc_pkg.sv =====
// shared constants and types for the modbus frame checker
// function codes, error codes, register indexes and the latched frame record
// no dependencies
package mfc_pkg;

  localparam int FRAME_LEN_W = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int COUNT_W     = 16;

  // function codes
  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT    = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
  localparam logic [7:0] FC_WRITE_REG     = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS    = 8'd16;
  localparam logic [7:0] FC_REPORT_ID     = 8'd17;
  localparam logic [7:0] FC_MASK_WRITE    = 8'd22;
  localparam logic [7:0] FC_WRITE_READ    = 8'd23;
  localparam logic [7:0] EXCEPTION_BIT    = 8'h80;

  // error codes
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd1;
  localparam logic [2:0] ERR_TOO_SHORT = 3'd2;
  localparam logic [2:0] ERR_INTEGRITY = 3'd3;
  localparam logic [2:0] ERR_EXCEPTION = 3'd4;
  localparam logic [2:0] ERR_LENGTH    = 3'd5;
  localparam logic [2:0] ERR_FUNCTION  = 3'd6;
  localparam logic [2:0] ERR_COUNT     = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECV_BUFFER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_BUFFER    = 3'd4;

  typedef struct packed {
    logic                   confirm;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic                   integrity_ok;
    logic [7:0]             function_code;
    logic [7:0]             byte_at_1;
    logic [7:0]             byte_at_3;
    logic [7:0]             byte_at_4;
    logic [7:0]             byte_at_5;
    logic [7:0]             byte_at_9;
    logic [7:0]             req_function;
    logic [COUNT_W-1:0]     req_count;
  } frame_t;

endpackage

// ===== design/modbus_frame_checker_unit.sv =====
// modbus frame checker: done follows start through the input and result registers
// one frame accepted every cycle; busy is always low, results cannot be stalled
// input register -> length and response checks -> result register
// reset: config registers to their defaults (header 1, checksum 2, limits 256),
// no frame pending and no done strobe
// depends on mfc_pkg
module modbus_frame_checker_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic [mfc_pkg::FRAME_LEN_W-1:0] frame_length,
  input  logic                          integrity_ok,
  input  logic [7:0]                    function_code,
  input  logic [7:0]                    byte_at_1,
  input  logic [7:0]                    byte_at_3,
  input  logic [7:0]                    byte_at_4,
  input  logic [7:0]                    byte_at_5,
  input  logic [7:0]                    byte_at_9,
  input  logic [7:0]                    req_function,
  input  logic [mfc_pkg::COUNT_W-1:0]   req_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          done,
  output logic                          pass,
  output logic [2:0]                    error_code,
  output logic [mfc_pkg::COUNT_W-1:0]   value_count
);
  import mfc_pkg::*;

  logic [2:0]             header_bytes;
  logic [1:0]             checksum_bytes;
  logic [FRAME_LEN_W-1:0] max_frame_bytes;
  logic [FRAME_LEN_W-1:0] receive_buffer_bytes;
  logic [FRAME_LEN_W-1:0] send_buffer_bytes;

  frame_t frame;
  logic   frame_valid;

  logic [4:0]         min_request;
  logic [3:0]         meta;
  logic [7:0]         data;
  logic [9:0]         need;
  logic [16:0]        rcnt_up;
  logic [13:0]        coil_bytes;
  logic [17:0]        expect_body;
  logic [17:0]        expect_len;
  logic               undefined_len;
  logic [COUNT_W-1:0] req_nb;
  logic [COUNT_W-1:0] rsp_nb;
  logic [2:0]         err_next;
  logic [COUNT_W-1:0] count_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes         <= 3'd1;
      checksum_bytes       <= 2'd2;
      max_frame_bytes      <= 10'd256;
      receive_buffer_bytes <= 10'd256;
      send_buffer_bytes    <= 10'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER_BYTES:   header_bytes         <= cfg_data[2:0];
        REG_CHECKSUM_BYTES: checksum_bytes       <= cfg_data[1:0];
        REG_MAX_FRAME:      max_frame_bytes      <= cfg_data;
        REG_RECV_BUFFER:    receive_buffer_bytes <= cfg_data;
        REG_SEND_BUFFER:    send_buffer_bytes    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else begin
      frame_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      frame.confirm       <= func;
      frame.frame_length  <= frame_length;
      frame.integrity_ok  <= integrity_ok;
      frame.function_code <= function_code;
      frame.byte_at_1     <= byte_at_1;
      frame.byte_at_3     <= byte_at_3;
      frame.byte_at_4     <= byte_at_4;
      frame.byte_at_5     <= byte_at_5;
      frame.byte_at_9     <= byte_at_9;
      frame.req_function  <= req_function;
      frame.req_count     <= req_count;
    end
  end

  // meta bytes and announced data bytes for the received function
  always_comb begin
    meta = 4'd0;
    data = 8'd0;
    if (!frame.confirm) begin
      if (frame.function_code <= FC_WRITE_REG) begin
        meta = 4'd4;
      end else begin
        case (frame.function_code)
          FC_WRITE_COILS, FC_WRITE_REGS: begin
            meta = 4'd5;
            data = frame.byte_at_5;
          end
          FC_MASK_WRITE: meta = 4'd6;
          FC_WRITE_READ: begin
            meta = 4'd9;
            data = frame.byte_at_9;
          end
          default: meta = 4'd0;
        endcase
      end
    end else begin
      case (frame.function_code)
        FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
        FC_REPORT_ID, FC_WRITE_READ: meta = 4'd1;
        FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: meta = 4'd4;
        FC_MASK_WRITE: meta = 4'd6;
        default: meta = 4'd0;
      endcase
      // code zero reads a byte count too
      if (frame.function_code <= FC_READ_INPUT || frame.function_code == FC_REPORT_ID ||
          frame.function_code == FC_WRITE_READ) begin
        data = frame.byte_at_1;
      end
    end
  end

  assign min_request = {2'b0, header_bytes} + 5'd5 + {3'b0, checksum_bytes};
  assign need = {7'b0, header_bytes} + 10'd1 + {6'b0, meta} + {2'b0, data}
              + {8'b0, checksum_bytes};

  assign rcnt_up    = {1'b0, frame.req_count} + 17'd7;
  assign coil_bytes = rcnt_up[16:3];

  // expected response length from the saved request
  always_comb begin
    undefined_len = 1'b0;
    case (frame.req_function)
      FC_READ_COILS, FC_READ_DISCRETE: expect_body = 18'd2 + {4'b0, coil_bytes};
      FC_WRITE_READ, FC_READ_HOLDING, FC_READ_INPUT:
        expect_body = 18'd2 + {1'b0, frame.req_count, 1'b0};
      FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: expect_body = 18'd5;
      FC_MASK_WRITE: expect_body = 18'd7;
      default: begin
        expect_body   = 18'd0;
        undefined_len = 1'b1;
      end
    endcase
  end

  assign expect_len = expect_body + {15'b0, header_bytes} + {16'b0, checksum_bytes};

  // value counts of request and response
  always_comb begin
    case (frame.function_code)
      FC_READ_COILS, FC_READ_DISCRETE: begin
        req_nb = {2'b0, coil_bytes};
        rsp_nb = {8'b0, frame.byte_at_1};
      end
      FC_WRITE_READ, FC_READ_HOLDING, FC_READ_INPUT: begin
        req_nb = frame.req_count;
        rsp_nb = {9'b0, frame.byte_at_1[7:1]};
      end
      FC_WRITE_COILS, FC_WRITE_REGS: begin
        req_nb = frame.req_count;
        rsp_nb = {frame.byte_at_3, frame.byte_at_4};
      end
      FC_REPORT_ID: begin
        req_nb = {8'b0, frame.byte_at_1};
        rsp_nb = {8'b0, frame.byte_at_1};
      end
      default: begin
        req_nb = 16'd1;
        rsp_nb = 16'd1;
      end
    endcase
  end

  // checks in priority order
  always_comb begin
    err_next   = ERR_OK;
    count_next = '0;
    if (frame.confirm && send_buffer_bytes < {5'b0, min_request}) begin
      err_next = ERR_TOO_LONG;
    end else if (frame.frame_length == '0) begin
      err_next = ERR_TOO_SHORT;
    end else if (frame.frame_length > receive_buffer_bytes ||
                 frame.frame_length > max_frame_bytes) begin
      err_next = ERR_TOO_LONG;
    end else if (frame.frame_length < need) begin
      err_next = ERR_TOO_SHORT;
    end else if (!frame.integrity_ok) begin
      err_next = ERR_INTEGRITY;
    end else if (!frame.confirm) begin
      count_next = {6'b0, frame.frame_length};
    end else if (frame.function_code >= EXCEPTION_BIT) begin
      err_next = ERR_EXCEPTION;
    end else if (!undefined_len && {8'b0, frame.frame_length} != expect_len) begin
      err_next = ERR_LENGTH;
    end else if (frame.function_code != frame.req_function) begin
      err_next = ERR_FUNCTION;
    end else if (req_nb != rsp_nb) begin
      err_next = ERR_COUNT;
    end else begin
      count_next = rsp_nb;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid) begin
      pass        <= (err_next == ERR_OK);
      error_code  <= err_next;
      value_count <= count_next;
    end
  end

endmodule
